// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked checks on clk_i, switched off while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// ===== rtl/core/qeti_pkg.sv =====
// ---------------------------------------------------------------------------
// qeti_pkg
// Shared widths, register indexes, multiplier interface types and
// saturating 64-bit arithmetic for the quartic escape-time iterator.
// ---------------------------------------------------------------------------
package qeti_pkg;

  localparam int WORD_W  = 64;
  localparam int PROD_W  = 128;
  localparam int POINT_W = 32;
  localparam int MAG_W   = 50;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_JULIA_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_JULIA_CONST_RE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JULIA_CONST_IM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERATIONS = 3'd3;

  localparam logic [WORD_W-1:0] S64_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] S64_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  // Request to the shared multiplier; half selects the doubled-product shift
  typedef struct packed {
    logic              start;
    logic              half;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] res;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
    logic [WORD_W:0] r;
    r = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    if (r[WORD_W] != r[WORD_W-1]) begin
      sat_add = r[WORD_W] ? S64_MIN : S64_MAX;
    end else begin
      sat_add = r[WORD_W-1:0];
    end
  endfunction

  function automatic logic [WORD_W-1:0] sat_sub(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
    logic [WORD_W:0] r;
    r = {a[WORD_W-1], a} - {b[WORD_W-1], b};
    if (r[WORD_W] != r[WORD_W-1]) begin
      sat_sub = r[WORD_W] ? S64_MIN : S64_MAX;
    end else begin
      sat_sub = r[WORD_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/qeti_mul.sv =====
// ---------------------------------------------------------------------------
// qeti_mul
// Shared 64x64 signed multiplier built from one 32x32 unsigned multiplier.
// Four partial products accumulate into a 128-bit register, then the
// product is shifted down, rounded toward minus infinity and saturated.
// ---------------------------------------------------------------------------
module qeti_mul import qeti_pkg::*; #(
  parameter int FRAC_BITS = 43
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  localparam int HALF_W = WORD_W / 2;
  localparam logic [PROD_W-1:0] MASK_F = (128'd1 << FRAC_BITS) - 128'd1;
  localparam logic [PROD_W-1:0] MASK_H = (128'd1 << (FRAC_BITS - 1)) - 128'd1;
  localparam logic [2:0] LAST_MUL_STEP = 3'd3;
  localparam logic [2:0] FINAL_STEP    = 3'd5;

  logic              act_q, act_d;
  logic [2:0]        step_q, step_d;
  logic              done_q, done_d;
  logic              pp_vld_q, pp_vld_d;
  logic [WORD_W-1:0] ma_q, ma_d, mb_q, mb_d;
  logic              neg_q, neg_d, half_q, half_d;
  logic [WORD_W-1:0] pp_q, pp_d;
  logic [1:0]        ppsh_q, ppsh_d;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic [WORD_W-1:0] res_q, res_d;

  logic [HALF_W-1:0] op_a, op_b;
  logic [PROD_W-1:0] pp_ext, pp_aligned;
  logic [PROD_W-1:0] quo, quo_inc;
  logic              rem_nz;
  logic [WORD_W-1:0] fin;

  // Partial product order: lo*lo, lo*hi, hi*lo, hi*hi
  assign op_a = step_q[1] ? ma_q[WORD_W-1:HALF_W] : ma_q[HALF_W-1:0];
  assign op_b = step_q[0] ? mb_q[WORD_W-1:HALF_W] : mb_q[HALF_W-1:0];
  assign pp_ext = {{(PROD_W-WORD_W){1'b0}}, pp_q};

  always_comb begin
    case (ppsh_q)
      2'd0:    pp_aligned = pp_ext;
      2'd1:    pp_aligned = pp_ext << HALF_W;
      2'd2:    pp_aligned = pp_ext << WORD_W;
      default: pp_aligned = '0;
    endcase
  end

  always_comb begin
    quo    = half_q ? (acc_q >> (FRAC_BITS - 1)) : (acc_q >> FRAC_BITS);
    rem_nz = half_q ? |(acc_q & MASK_H) : |(acc_q & MASK_F);
    quo_inc = quo + {{(PROD_W-1){1'b0}}, rem_nz};
    if (!neg_q) begin
      fin = (|quo[PROD_W-1:WORD_W-1]) ? S64_MAX : quo[WORD_W-1:0];
    end else begin
      fin = (|quo_inc[PROD_W-1:WORD_W-1]) ? S64_MIN : (~quo_inc[WORD_W-1:0] + 64'd1);
    end
  end

  always_comb begin
    act_d    = act_q;
    step_d   = step_q;
    done_d   = 1'b0;
    pp_vld_d = 1'b0;
    ma_d     = ma_q;
    mb_d     = mb_q;
    neg_d    = neg_q;
    half_d   = half_q;
    pp_d     = pp_q;
    ppsh_d   = ppsh_q;
    acc_d    = acc_q;
    res_d    = res_q;
    if (req_i.start) begin
      act_d  = 1'b1;
      step_d = '0;
      ma_d   = req_i.a[WORD_W-1] ? (~req_i.a + 64'd1) : req_i.a;
      mb_d   = req_i.b[WORD_W-1] ? (~req_i.b + 64'd1) : req_i.b;
      neg_d  = req_i.a[WORD_W-1] ^ req_i.b[WORD_W-1];
      half_d = req_i.half;
      acc_d  = '0;
    end else if (act_q) begin
      step_d = step_q + 3'd1;
      if (step_q <= LAST_MUL_STEP) begin
        pp_d     = op_a * op_b;
        ppsh_d   = {1'b0, step_q[1]} + {1'b0, step_q[0]};
        pp_vld_d = 1'b1;
      end
      if (pp_vld_q) begin
        acc_d = acc_q + pp_aligned;
      end
      if (step_q == FINAL_STEP) begin
        res_d  = fin;
        done_d = 1'b1;
        act_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= 1'b0;
      step_q   <= '0;
      done_q   <= 1'b0;
      pp_vld_q <= 1'b0;
    end else begin
      act_q    <= act_d;
      step_q   <= step_d;
      done_q   <= done_d;
      pp_vld_q <= pp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    neg_q  <= neg_d;
    half_q <= half_d;
    pp_q   <= pp_d;
    ppsh_q <= ppsh_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;
  assign rsp_o.prod = acc_q;

endmodule

// ===== rtl/core/quartic_escape_time_iterator.sv =====
// ---------------------------------------------------------------------------
// Quartic escape-time iterator
// Iterates z <- z^4 - z + k on one complex point in fixed point and reports
// the escape count, an escaped flag and the saturated |z|^2 at escape.
// ---------------------------------------------------------------------------
//  channel  | handshake                    | payload
//  ---------+------------------------------+----------------------------------
//  input    | in_valid_i / in_ready_o      | point_real_i, point_imag_i
//  output   | out_valid_o / out_ready_i    | iteration_count_o, escaped_o,
//           |                              | final_magnitude_sq_o
//  config   | cfg_we_i (no wait)           | cfg_index_i, cfg_wdata_i
//
//  A transaction iterates until the limit n is reached or the point escapes:
//  each iteration issues six products to the shared 32x32-based multiplier,
//  one after another, plus the sequencer states S_TEST, S_CMP and S_ADD; the
//  escape test costs two products, x*x and y*y.
//  in_ready_o is high only while the sequencer is idle; the next point may
//  be taken while a result waits in the output register.
//  A finished point holds in its last state until the output register frees.
//  Reset clears control state and loads the register defaults; no sweep.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module quartic_escape_time_iterator import qeti_pkg::*; #(
  parameter int ITER_WIDTH = 16,
  parameter int FRAC_BITS  = 43
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [POINT_W-1:0]   point_real_i,
  input  logic [POINT_W-1:0]   point_imag_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [15:0]          iteration_count_o,
  output logic                 escaped_o,
  output logic [MAG_W-1:0]     final_magnitude_sq_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [POINT_W-1:0]   cfg_wdata_i
);

  localparam int UP_SH  = (FRAC_BITS >= 27) ? FRAC_BITS - 27 : 0;
  localparam int DN_SH  = (FRAC_BITS < 27) ? 27 - FRAC_BITS : 0;
  localparam int MAG_SH = 2 * FRAC_BITS - 16;
  localparam logic [PROD_W-1:0] MAG_THR = 128'd1 << (8 + 2 * FRAC_BITS);
  localparam logic [ITER_WIDTH+15:0] ITER_CAP = {16'd0, {ITER_WIDTH{1'b1}}};

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TEST = 4'd1;
  localparam logic [3:0] S_XX   = 4'd2;
  localparam logic [3:0] S_YY   = 4'd3;
  localparam logic [3:0] S_CMP  = 4'd4;
  localparam logic [3:0] S_XY   = 4'd5;
  localparam logic [3:0] S_AA   = 4'd6;
  localparam logic [3:0] S_BB   = 4'd7;
  localparam logic [3:0] S_AB   = 4'd8;
  localparam logic [3:0] S_ADD  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  function automatic logic [WORD_W-1:0] from_q27(input logic [POINT_W-1:0] raw);
    logic signed [WORD_W-1:0] v;
    v = $signed({{(WORD_W-POINT_W){raw[POINT_W-1]}}, raw});
    from_q27 = (v <<< UP_SH) >>> DN_SH;
  endfunction

  logic [3:0]            state_q, state_d;
  logic                  julia_mode_q;
  logic [POINT_W-1:0]    jc_re_q, jc_im_q;
  logic [15:0]           max_iter_q;
  logic [WORD_W-1:0]     x_q, x_d, y_q, y_d, kr_q, kr_d, ki_q, ki_d;
  logic [WORD_W-1:0]     t1_q, t1_d, z2r_q, z2r_d, z2i_q, z2i_d, z4r_q, z4r_d;
  logic [PROD_W-1:0]     msum_q, msum_d;
  logic [ITER_WIDTH-1:0] cnt_q, cnt_d, limit_q, limit_d;
  logic                  esc_q, esc_d;
  logic                  out_valid_q, out_valid_d;
  logic [15:0]           out_cnt_q, out_cnt_d;
  logic                  out_esc_q, out_esc_d;
  logic [MAG_W-1:0]      out_mag_q, out_mag_d;

  logic [ITER_WIDTH+15:0] lim_ext, lim_sel, cnt_ext;
  logic [PROD_W-1:0]      mag_shifted;
  logic [MAG_W-1:0]       mag_sat;
  mul_req_t               mul_req;
  mul_rsp_t               mul_rsp;

  qeti_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  assign lim_ext = {{ITER_WIDTH{1'b0}}, max_iter_q};
  assign lim_sel = (lim_ext > ITER_CAP) ? ITER_CAP : lim_ext;
  assign cnt_ext = {16'd0, cnt_q};
  assign mag_shifted = msum_q >> MAG_SH;
  assign mag_sat = (|mag_shifted[PROD_W-1:MAG_W]) ? {MAG_W{1'b1}}
                                                  : mag_shifted[MAG_W-1:0];

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    kr_d        = kr_q;
    ki_d        = ki_q;
    t1_d        = t1_q;
    z2r_d       = z2r_q;
    z2i_d       = z2i_q;
    z4r_d       = z4r_q;
    msum_d      = msum_q;
    cnt_d       = cnt_q;
    limit_d     = limit_q;
    esc_d       = esc_q;
    out_valid_d = out_valid_q;
    out_cnt_d   = out_cnt_q;
    out_esc_d   = out_esc_q;
    out_mag_d   = out_mag_q;
    mul_req     = '{start: 1'b0, half: 1'b0, a: x_q, b: x_q};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (julia_mode_q) begin
            x_d  = from_q27(point_real_i);
            y_d  = from_q27(point_imag_i);
            kr_d = from_q27(jc_re_q);
            ki_d = from_q27(jc_im_q);
          end else begin
            x_d  = '0;
            y_d  = '0;
            kr_d = from_q27(point_real_i);
            ki_d = from_q27(point_imag_i);
          end
          cnt_d   = '0;
          limit_d = lim_sel[ITER_WIDTH-1:0];
          esc_d   = 1'b0;
          state_d = S_TEST;
        end
      end
      S_TEST: begin
        if (cnt_q == limit_q) begin
          state_d = S_DONE;
        end else begin
          mul_req = '{start: 1'b1, half: 1'b0, a: x_q, b: x_q};
          state_d = S_XX;
        end
      end
      S_XX: begin
        if (mul_rsp.done) begin
          t1_d    = mul_rsp.res;
          msum_d  = mul_rsp.prod;
          mul_req = '{start: 1'b1, half: 1'b0, a: y_q, b: y_q};
          state_d = S_YY;
        end
      end
      S_YY: begin
        if (mul_rsp.done) begin
          msum_d  = msum_q + mul_rsp.prod;
          z2r_d   = sat_sub(t1_q, mul_rsp.res);
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (msum_q > MAG_THR) begin
          esc_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          mul_req = '{start: 1'b1, half: 1'b1, a: x_q, b: y_q};
          state_d = S_XY;
        end
      end
      S_XY: begin
        if (mul_rsp.done) begin
          z2i_d   = mul_rsp.res;
          mul_req = '{start: 1'b1, half: 1'b0, a: z2r_q, b: z2r_q};
          state_d = S_AA;
        end
      end
      S_AA: begin
        if (mul_rsp.done) begin
          t1_d    = mul_rsp.res;
          mul_req = '{start: 1'b1, half: 1'b0, a: z2i_q, b: z2i_q};
          state_d = S_BB;
        end
      end
      S_BB: begin
        if (mul_rsp.done) begin
          z4r_d   = sat_sub(t1_q, mul_rsp.res);
          mul_req = '{start: 1'b1, half: 1'b1, a: z2r_q, b: z2i_q};
          state_d = S_AB;
        end
      end
      S_AB: begin
        if (mul_rsp.done) begin
          x_d     = sat_sub(z4r_q, x_q);
          y_d     = sat_sub(mul_rsp.res, y_q);
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        x_d     = sat_add(x_q, kr_q);
        y_d     = sat_add(y_q, ki_q);
        cnt_d   = cnt_q + {{(ITER_WIDTH-1){1'b0}}, 1'b1};
        state_d = S_TEST;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_cnt_d   = cnt_ext[15:0];
          out_esc_d   = esc_q;
          out_mag_d   = esc_q ? mag_sat : '0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      julia_mode_q <= 1'b0;
      jc_re_q      <= '0;
      jc_im_q      <= '0;
      max_iter_q   <= 16'd256;
      cnt_q        <= '0;
      limit_q      <= '0;
      esc_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      limit_q     <= limit_d;
      esc_q       <= esc_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_JULIA_MODE:     julia_mode_q <= cfg_wdata_i[0];
          CFG_JULIA_CONST_RE: jc_re_q      <= cfg_wdata_i;
          CFG_JULIA_CONST_IM: jc_im_q      <= cfg_wdata_i;
          CFG_MAX_ITERATIONS: max_iter_q   <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    y_q       <= y_d;
    kr_q      <= kr_d;
    ki_q      <= ki_d;
    t1_q      <= t1_d;
    z2r_q     <= z2r_d;
    z2i_q     <= z2i_d;
    z4r_q     <= z4r_d;
    msum_q    <= msum_d;
    out_cnt_q <= out_cnt_d;
    out_esc_q <= out_esc_d;
    out_mag_q <= out_mag_d;
  end

  assign out_valid_o          = out_valid_q;
  assign iteration_count_o    = out_cnt_q;
  assign escaped_o            = out_esc_q;
  assign final_magnitude_sq_o = out_mag_q;

  `ASSERT_IMPL(a_idle_mul_quiet, in_ready_o, !mul_rsp.done)
  `ASSERT_NEXT(a_mul_latency, mul_req.start, !mul_rsp.done)
  `ASSERT_IMPL(a_count_bounded, state_q != S_IDLE, cnt_q <= limit_q)
  `ASSERT_IMPL(a_done_reason, state_q == S_DONE, esc_q || (cnt_q == limit_q))

endmodule
